[rtl/cea_pkg.sv]
// Shared constants and types for the contiguous extent allocator.
package cea_pkg;

    localparam int CMD_W  = 3;
    localparam int KEY_W  = 64;
    localparam int SIZE_W = 11;
    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int STAT_W = 3;
    localparam int FREE_W = 11;

    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COMPACT = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd2;
    localparam logic [STAT_W-1:0] ST_ZERO     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOSPACE  = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOFILE   = 3'd5;
    localparam logic [STAT_W-1:0] ST_BADBLOCK = 3'd6;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DEC  = 9'b000000010,
        S_SCAN = 9'b000000100,
        S_FILL = 9'b000001000,
        S_RDW  = 9'b000010000,
        S_PICK = 9'b000100000,
        S_CPRD = 9'b001000000,
        S_CPWR = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

endpackage

[rtl/cea_ram.sv]
// Generic simple dual-port RAM with registered read.
module cea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/contiguous_extent_allocator_unit.sv]
// Top level: directory registers, block store RAM and command sequencer.
// Create runs a first-fit scan over the store, one block per cycle, and then fills each
// block of the found extent; read passes through a state that takes the registered RAM read.
// Compact: per extent a search over all MAX_FILES slots, then a read and a write per copied block,
// plus a final search that finds no extent left.
// One command is in work at a time; the result register frees the input side.
// Reset (synchronous, active low) clears the directory and control; no clearing pass.
module contiguous_extent_allocator_unit
    import cea_pkg::*;
#(
    parameter int DISK_BLOCKS = 1024,
    parameter int MAX_FILES   = 16,
    parameter int NAME_CHARS  = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic [KEY_W-1:0]         i_file_key,
    input  logic [SIZE_W-1:0]        i_extent_size,
    input  logic [IDX_W-1:0]         i_block_index,
    input  logic signed [DATA_W-1:0] i_write_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_read_data,
    output logic [FREE_W-1:0]        o_free_count
);
    localparam int AW = $clog2(DISK_BLOCKS);
    localparam int CW = $clog2(DISK_BLOCKS + 1);
    localparam int SW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int EW = ((AW > IDX_W) ? AW : IDX_W) + 1;
    localparam int FW = $clog2(MAX_FILES);
    localparam int NB = 8 * NAME_CHARS;
    localparam logic [KEY_W-1:0] NAME_MASK = {KEY_W{1'b1}} >> (KEY_W - NB);

    t_state r_state, n_state;

    logic [CMD_W-1:0]  r_cmd;
    logic [KEY_W-1:0]  r_name;
    logic [SW-1:0]     r_size;
    logic [IDX_W-1:0]  r_index;
    logic [DATA_W-1:0] r_wdata;

    logic [KEY_W-1:0]  r_dname [MAX_FILES];
    logic [AW-1:0]     r_dstart [MAX_FILES];
    logic [CW-1:0]     r_dlen [MAX_FILES];
    logic [CW-1:0]     r_used;

    logic [AW-1:0]     r_b;
    logic [CW-1:0]     r_run;
    logic [AW-1:0]     r_fa;
    logic [CW-1:0]     r_cnt;
    logic [FW-1:0]     r_i;
    logic              r_pv;
    logic [FW-1:0]     r_pick;
    logic [AW-1:0]     r_pstart;
    logic [MAX_FILES-1:0] r_done;
    logic [CW-1:0]     r_next;
    logic [AW-1:0]     r_k;

    logic [STAT_W-1:0] r_st;
    logic [DATA_W-1:0] r_rd;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [DATA_W-1:0] r_out_rdata;
    logic [FREE_W-1:0] r_out_free;

    logic              any_empty, dup, hit, alloc;
    logic [FW-1:0]     empty_idx, hit_idx;
    logic [CW-1:0]     hit_len;
    logic [EW-1:0]     loc_addr;
    logic [CW-1:0]     run_n;
    logic [SW-1:0]     scan_start;
    logic [SW-1:0]     free_w;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    wire accept = i_in_valid && !o_in_stall;

    always_comb begin
        any_empty = 1'b0;
        dup       = 1'b0;
        hit       = 1'b0;
        alloc     = 1'b0;
        empty_idx = '0;
        hit_idx   = '0;
        for (int i = MAX_FILES - 1; i >= 0; i--) begin
            if (r_dlen[i] == '0) begin
                any_empty = 1'b1;
                empty_idx = FW'(i);
            end
            if (r_dname[i] == r_name) begin
                dup = 1'b1;
            end
            if (r_name != '0 && r_dlen[i] != '0 && r_dname[i] == r_name) begin
                hit     = 1'b1;
                hit_idx = FW'(i);
            end
            if (r_dlen[i] != '0 && r_b >= r_dstart[i]
                && {1'b0, r_b} < ({1'b0, r_dstart[i]} + (AW + 1)'(r_dlen[i]))) begin
                alloc = 1'b1;
            end
        end
    end

    assign hit_len    = r_dlen[hit_idx];
    assign loc_addr   = EW'(r_dstart[hit_idx]) + EW'(r_index);
    assign run_n      = alloc ? '0 : r_run + CW'(1);
    assign scan_start = SW'(r_b) + SW'(1) - r_size;
    assign free_w     = SW'(DISK_BLOCKS) - SW'(r_used);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_fa;
        ram_wdata = DATA_W'(1);
        ram_raddr = AW'(loc_addr);
        case (r_state)
            S_DEC: begin
                ram_we    = (r_cmd == CMD_WRITE) && hit && (SW'(r_index) < SW'(hit_len))
                            && (loc_addr < EW'(DISK_BLOCKS));
                ram_waddr = AW'(loc_addr);
                ram_wdata = r_wdata;
            end
            S_FILL: begin
                ram_we = 1'b1;
            end
            S_CPRD: begin
                ram_raddr = r_pstart + r_k;
            end
            S_CPWR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_next) + r_k;
                ram_wdata = ram_rdata;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    cea_ram #(.WIDTH(DATA_W), .DEPTH(DISK_BLOCKS)) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_DEC;
            S_DEC: begin
                case (r_cmd)
                    CMD_CREATE: begin
                        if (any_empty && !dup && r_size != '0 && r_size <= SW'(DISK_BLOCKS))
                            n_state = S_SCAN;
                        else
                            n_state = S_DONE;
                    end
                    CMD_READ: begin
                        if (hit && SW'(r_index) < SW'(hit_len) && loc_addr < EW'(DISK_BLOCKS))
                            n_state = S_RDW;
                        else
                            n_state = S_DONE;
                    end
                    CMD_COMPACT: n_state = S_PICK;
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (SW'(run_n) == r_size) n_state = S_FILL;
                else if (r_b == AW'(DISK_BLOCKS - 1)) n_state = S_DONE;
            end
            S_FILL: if (SW'(r_cnt) + SW'(1) == r_size) n_state = S_DONE;
            S_RDW: n_state = S_DONE;
            S_PICK: begin
                if (r_i == FW'(MAX_FILES - 1)) begin
                    if (r_pv || (r_dlen[r_i] != '0 && !r_done[r_i])) n_state = S_CPRD;
                    else n_state = S_DONE;
                end
            end
            S_CPRD: n_state = S_CPWR;
            S_CPWR: begin
                if (CW'(r_k) + CW'(1) == r_dlen[r_pick]) n_state = S_PICK;
                else n_state = S_CPRD;
            end
            S_DONE: if (!(r_out_valid && i_out_stall)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_used      <= '0;
            for (int i = 0; i < MAX_FILES; i++) begin
                r_dname[i]  <= '0;
                r_dstart[i] <= '0;
                r_dlen[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && !(r_out_valid && i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cmd   <= i_cmd;
                    r_name  <= i_file_key & NAME_MASK;
                    r_size  <= SW'(i_extent_size);
                    r_index <= i_block_index;
                    r_wdata <= i_write_data;
                end
                S_DEC: begin
                    r_rd   <= '0;
                    r_b    <= '0;
                    r_run  <= '0;
                    r_cnt  <= '0;
                    r_i    <= '0;
                    r_pv   <= 1'b0;
                    r_done <= '0;
                    r_next <= '0;
                    case (r_cmd)
                        CMD_CREATE: begin
                            if (!any_empty) r_st <= ST_FULL;
                            else if (dup) r_st <= ST_DUP;
                            else if (r_size == '0) r_st <= ST_ZERO;
                            else if (r_size > SW'(DISK_BLOCKS)) r_st <= ST_NOSPACE;
                            else r_st <= ST_OK;
                        end
                        CMD_DELETE: begin
                            if (!hit) begin
                                r_st <= ST_NOFILE;
                            end else begin
                                r_st              <= ST_OK;
                                r_dname[hit_idx]  <= '0;
                                r_dstart[hit_idx] <= '0;
                                r_dlen[hit_idx]   <= '0;
                                r_used            <= r_used - hit_len;
                            end
                        end
                        CMD_WRITE, CMD_READ: begin
                            if (!hit) r_st <= ST_NOFILE;
                            else if (SW'(r_index) >= SW'(hit_len)) r_st <= ST_BADBLOCK;
                            else if (loc_addr >= EW'(DISK_BLOCKS)) r_st <= ST_BADBLOCK;
                            else r_st <= ST_OK;
                        end
                        default: begin
                            r_st <= ST_OK;
                        end
                    endcase
                end
                S_SCAN: begin
                    r_run <= run_n;
                    r_b   <= r_b + AW'(1);
                    r_fa  <= scan_start[AW-1:0];
                    if (SW'(run_n) != r_size && r_b == AW'(DISK_BLOCKS - 1)) begin
                        r_st <= ST_NOSPACE;
                    end
                end
                S_FILL: begin
                    r_fa  <= r_fa + AW'(1);
                    r_cnt <= r_cnt + CW'(1);
                    if (SW'(r_cnt) + SW'(1) == r_size) begin
                        r_dname[empty_idx]  <= r_name;
                        r_dstart[empty_idx] <= r_fa - AW'(r_cnt);
                        r_dlen[empty_idx]   <= CW'(r_size);
                        r_used              <= r_used + CW'(r_size);
                    end
                end
                S_RDW: begin
                    r_rd <= ram_rdata;
                end
                S_PICK: begin
                    if (r_dlen[r_i] != '0 && !r_done[r_i]
                        && (!r_pv || r_dstart[r_i] < r_pstart)) begin
                        r_pv     <= 1'b1;
                        r_pick   <= r_i;
                        r_pstart <= r_dstart[r_i];
                    end
                    r_i <= (r_i == FW'(MAX_FILES - 1)) ? '0 : r_i + FW'(1);
                    r_k <= '0;
                end
                S_CPWR: begin
                    r_k <= r_k + AW'(1);
                    if (CW'(r_k) + CW'(1) == r_dlen[r_pick]) begin
                        r_dstart[r_pick] <= AW'(r_next);
                        r_next           <= r_next + r_dlen[r_pick];
                        r_done[r_pick]   <= 1'b1;
                        r_pv             <= 1'b0;
                    end
                end
                S_DONE: begin
                    if (!(r_out_valid && i_out_stall)) begin
                        r_out_status <= r_st;
                        r_out_rdata  <= r_rd;
                        r_out_free   <= free_w[FREE_W-1:0];
                    end
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_data  = r_out_rdata;
    assign o_free_count = r_out_free;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(DISK_BLOCKS))
        else $error("used block count beyond store size");
    a_accept_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_DEC)
        else $error("accepted word not decoded");
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word loaded outside completion");
    a_copy_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CPRD |-> {1'b0, r_next} <= (CW + 1)'(r_pstart))
        else $error("compaction moves an extent upward");
endmodule

[verif/tb_top.sv]
// Testbench top: drives random and directed commands and checks each result against a predictor.
`timescale 1ns / 100ps

module tb_top;
    import cea_pkg::*;

    localparam int BLOCKS   = 1024;
    localparam int FILES    = 16;
    localparam int N_RANDOM = 560;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] rdata;
        logic [FREE_W-1:0]        free;
    } t_result;

    class extent_scoreboard;
        logic [DATA_W-1:0] store [BLOCKS];
        bit                amap [BLOCKS];
        logic [KEY_W-1:0]  names [FILES];
        int unsigned       starts [FILES];
        int unsigned       lens [FILES];
        t_result           pending_q [$];
        int                errors;

        function new();
            for (int b = 0; b < BLOCKS; b++) begin
                store[b] = '0;
                amap[b]  = 0;
            end
            for (int i = 0; i < FILES; i++) begin
                names[i]  = '0;
                starts[i] = 0;
                lens[i]   = 0;
            end
            errors = 0;
        endfunction

        function int lookup(logic [KEY_W-1:0] key);
            if (key == '0) return -1;
            for (int i = 0; i < FILES; i++)
                if (lens[i] != 0 && names[i] == key) return i;
            return -1;
        endfunction

        function logic [STAT_W-1:0] create(logic [KEY_W-1:0] key, int unsigned size);
            int slot;
            int unsigned run;
            int unsigned start;
            bit found;
            slot  = -1;
            run   = 0;
            start = 0;
            found = 0;
            for (int i = 0; i < FILES; i++)
                if (slot < 0 && lens[i] == 0) slot = i;
            if (slot < 0) return ST_FULL;
            for (int i = 0; i < FILES; i++)
                if (names[i] == key) return ST_DUP;
            if (size == 0) return ST_ZERO;
            if (size > BLOCKS) return ST_NOSPACE;
            for (int b = 0; b < BLOCKS && !found; b++) begin
                run = amap[b] ? 0 : run + 1;
                if (run == size) begin
                    start = b + 1 - size;
                    found = 1;
                end
            end
            if (!found) return ST_NOSPACE;
            for (int unsigned b = start; b < start + size; b++) begin
                store[b] = 32'd1;
                amap[b]  = 1;
            end
            names[slot]  = key;
            starts[slot] = start;
            lens[slot]   = size;
            return ST_OK;
        endfunction

        function void compact();
            bit done [FILES];
            int unsigned nxt;
            int pick;
            nxt = 0;
            for (int i = 0; i < FILES; i++) done[i] = 0;
            for (int pass = 0; pass < FILES; pass++) begin
                pick = -1;
                for (int i = 0; i < FILES; i++)
                    if (lens[i] != 0 && !done[i] && (pick < 0 || starts[i] < starts[pick]))
                        pick = i;
                if (pick >= 0) begin
                    done[pick] = 1;
                    for (int unsigned k = 0; k < lens[pick]; k++)
                        store[nxt + k] = store[starts[pick] + k];
                    starts[pick] = nxt;
                    nxt += lens[pick];
                end
            end
            for (int unsigned b = 0; b < BLOCKS; b++) begin
                amap[b] = (b < nxt);
                if (b >= nxt) store[b] = '0;
            end
        endfunction

        function void note(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                           logic [SIZE_W-1:0] size, logic [IDX_W-1:0] idx,
                           logic [DATA_W-1:0] wdata);
            t_result r;
            int slot;
            int unsigned nfree;
            r.status = ST_OK;
            r.rdata  = '0;
            nfree    = 0;
            case (cmd)
                CMD_CREATE: r.status = create(key, size);
                CMD_DELETE: begin
                    slot = lookup(key);
                    if (slot < 0) begin
                        r.status = ST_NOFILE;
                    end else begin
                        for (int unsigned b = starts[slot]; b < starts[slot] + lens[slot]; b++) begin
                            store[b] = '0;
                            amap[b]  = 0;
                        end
                        names[slot]  = '0;
                        starts[slot] = 0;
                        lens[slot]   = 0;
                    end
                end
                CMD_WRITE, CMD_READ: begin
                    slot = lookup(key);
                    if (slot < 0) r.status = ST_NOFILE;
                    else if (idx >= lens[slot]) r.status = ST_BADBLOCK;
                    else if (cmd == CMD_WRITE) store[starts[slot] + idx] = wdata;
                    else r.rdata = store[starts[slot] + idx];
                end
                CMD_COMPACT: compact();
                default: ;
            endcase
            for (int b = 0; b < BLOCKS; b++)
                if (!amap[b]) nfree++;
            r.free = nfree[FREE_W-1:0];
            pending_q.push_back(r);
        endfunction

        function void check(logic [STAT_W-1:0] status, logic [DATA_W-1:0] rdata,
                            logic [FREE_W-1:0] free);
            t_result exp_r;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: status %0d", status);
                return;
            end
            exp_r = pending_q.pop_front();
            if (status !== exp_r.status || rdata !== exp_r.rdata || free !== exp_r.free) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp st %0d rd %h free %0d, got st %0d rd %h free %0d",
                             exp_r.status, exp_r.rdata, exp_r.free, status, rdata, free);
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [CMD_W-1:0]         i_cmd;
    logic [KEY_W-1:0]         i_file_key;
    logic [SIZE_W-1:0]        i_extent_size;
    logic [IDX_W-1:0]         i_block_index;
    logic signed [DATA_W-1:0] i_write_data;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [STAT_W-1:0]        o_status;
    logic signed [DATA_W-1:0] o_read_data;
    logic [FREE_W-1:0]        o_free_count;

    extent_scoreboard sb;
    bit               quiet;
    int               idle_cycles;

    contiguous_extent_allocator_unit i_dut (.*);

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    initial begin
        i_rst_n       = 0;
        i_in_valid    = 0;
        i_out_stall   = 0;
        i_cmd         = '0;
        i_file_key    = '0;
        i_extent_size = '0;
        i_block_index = '0;
        i_write_data  = '0;
        quiet         = 0;
        idle_cycles   = 0;
        sb            = new();
    end

    always @(posedge i_clk) begin
        if (i_rst_n) i_out_stall <= !quiet && ($urandom_range(0, 99) < 27);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check(o_status, o_read_data, o_free_count);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    task automatic send_word(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                             logic [SIZE_W-1:0] size, logic [IDX_W-1:0] idx,
                             logic [DATA_W-1:0] wdata);
        if (!quiet && $urandom_range(0, 99) < 27) begin
            i_in_valid <= 0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 27);
        end
        i_in_valid    <= 1;
        i_cmd         <= cmd;
        i_file_key    <= key;
        i_extent_size <= size;
        i_block_index <= idx;
        i_write_data  <= wdata;
        do @(posedge i_clk); while (o_in_stall);
        sb.note(cmd, key, size, idx, wdata);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] live_name();
        int live [$];
        for (int i = 0; i < FILES; i++)
            if (sb.lens[i] != 0) live.push_back(i);
        if (live.size() == 0) return {$urandom, $urandom};
        return sb.names[live[$urandom_range(0, live.size() - 1)]];
    endfunction

    function automatic int unsigned live_len(logic [KEY_W-1:0] key);
        int slot;
        slot = sb.lookup(key);
        return (slot < 0) ? 1 : sb.lens[slot];
    endfunction

    task automatic random_word();
        int r;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        logic [IDX_W-1:0]  idx;
        logic [CMD_W-1:0]  cmd;
        r    = $urandom_range(0, 99);
        key  = live_name();
        size = SIZE_W'($urandom_range(1, 40));
        idx  = IDX_W'($urandom_range(0, live_len(key) - 1));
        if ($urandom_range(0, 9) == 0) idx = IDX_W'($urandom);
        if (r < 27) begin
            cmd = CMD_CREATE;
            if ($urandom_range(0, 9) != 0) key = {$urandom, $urandom};
            if ($urandom_range(0, 29) == 0) key = '0;
            case ($urandom_range(0, 19))
                0:       size = '0;
                1:       size = SIZE_W'($urandom_range(1025, 2047));
                2, 3:    size = SIZE_W'($urandom_range(41, 1024));
                default: ;
            endcase
        end else if (r < 47) begin
            cmd = CMD_DELETE;
            if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
        end else if (r < 67) begin
            cmd = CMD_WRITE;
        end else if (r < 87) begin
            cmd = CMD_READ;
        end else if (r < 93) begin
            cmd = CMD_COMPACT;
        end else begin
            cmd  = CMD_W'($urandom_range(0, 7));
            key  = {$urandom, $urandom};
            size = SIZE_W'($urandom);
            idx  = IDX_W'($urandom);
        end
        send_word(cmd, key, size, idx, $urandom);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_word(CMD_CREATE, '1, 11'd1024, '0, '0);
        send_word(CMD_DELETE, '1, '0, '0, '0);
        send_word(CMD_CREATE, '1, 11'd1, '0, '0);
        send_word(CMD_CREATE, 64'd1, 11'd1023, '0, '0);
        send_word(CMD_CREATE, 64'd2, 11'd1, '0, '0);
        send_word(CMD_WRITE, '1, '0, '0, 32'h8000_0000);
        send_word(CMD_READ, '1, '0, '0, '0);
        send_word(CMD_WRITE, 64'd1, '0, 10'd1022, 32'h7fff_ffff);
        send_word(CMD_READ, 64'd1, '0, 10'd1022, '0);
        send_word(CMD_READ, 64'd1, '0, 10'd1023, '0);
        send_word(CMD_WRITE, 64'd1, '0, 10'd1023, '1);
        send_word(CMD_READ, '0, '0, '0, '0);
        send_word(CMD_DELETE, 64'd3, '0, '0, '0);
        send_word(CMD_DELETE, '1, '0, '0, '0);
        send_word(CMD_CREATE, 64'd4, '0, '0, '0);
        send_word(CMD_CREATE, '0, 11'd1, '0, '0);
        send_word(CMD_CREATE, 64'd5, 11'd2047, '0, '0);
        send_word(CMD_COMPACT, '0, '0, '0, '0);
        send_word(CMD_READ, 64'd1, '0, 10'd1022, '0);
        send_word(3'd5, '1, '1, '1, '1);
        send_word(3'd7, '0, '0, '0, '0);
        send_word(CMD_DELETE, 64'd1, '0, '0, '0);
        send_word(CMD_COMPACT, '0, '0, '0, '0);
        send_word(CMD_COMPACT, '0, '0, '0, '0);

        for (int n = 0; n < N_RANDOM; n++) begin
            quiet = (n >= 150 && n < 250);
            if (n == 300) drain();
            random_word();
        end
        quiet = 0;
        drain();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
